>>> hw/rtl/md5_pkg.sv
`default_nettype none

package md5_pkg;

   // Datapath operation codes, one per microcode step
   localparam logic [3:0] OP_NOP      = 4'd0;
   localparam logic [3:0] OP_ABSORB   = 4'd1;
   localparam logic [3:0] OP_LOAD     = 4'd2;
   localparam logic [3:0] OP_ROUND    = 4'd3;
   localparam logic [3:0] OP_ADD      = 4'd4;
   localparam logic [3:0] OP_PADINIT  = 4'd5;
   localparam logic [3:0] OP_PADBYTE  = 4'd6;
   localparam logic [3:0] OP_CTX_PADA = 4'd7;
   localparam logic [3:0] OP_ZERO     = 4'd8;
   localparam logic [3:0] OP_LEN      = 4'd9;
   localparam logic [3:0] OP_EMIT     = 4'd10;
   localparam logic [3:0] OP_CLEAR    = 4'd11;

   // Chain initial values
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Control from sequencer to datapath
   typedef struct packed {
      logic       ready;
      logic [3:0] op;
   } ctrl_type;

   // Datapath status for the sequencer's jump conditions
   typedef struct packed {
      logic idle_next;
      logic not_full;
      logic round_more;
      logic ctx_final;
      logic ctx_pada;
      logic not_last;
      logic pad_more;
      logic not_wide;
      logic zero_more;
   } dp_stat_type;

   // Additive constants per step
   function automatic logic [31:0] md5_k(input logic [5:0] s);
      logic [31:0] k;
      case (s)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // Rotate amount per step
   function automatic logic [4:0] md5_rot(input logic [5:0] s);
      logic [4:0] r;
      case ({s[5:4], s[1:0]})
         4'd0:  r = 5'd7;   4'd1:  r = 5'd12;  4'd2:  r = 5'd17;  4'd3:  r = 5'd22;
         4'd4:  r = 5'd5;   4'd5:  r = 5'd9;   4'd6:  r = 5'd14;  4'd7:  r = 5'd20;
         4'd8:  r = 5'd4;   4'd9:  r = 5'd11;  4'd10: r = 5'd16;  4'd11: r = 5'd23;
         4'd12: r = 5'd6;   4'd13: r = 5'd10;  4'd14: r = 5'd15;  4'd15: r = 5'd21;
         default: r = 5'd7;
      endcase
      return r;
   endfunction

   // Message word index per step
   function automatic logic [3:0] md5_gidx(input logic [5:0] s);
      logic [3:0] t;
      logic [3:0] g;
      t = s[3:0];
      case (s[5:4])
         2'd0:    g = t;
         2'd1:    g = 4'((t << 2) + t + 4'd1);
         2'd2:    g = 4'((t << 1) + t + 4'd5);
         default: g = 4'((t << 3) - t);
      endcase
      return g;
   endfunction

   // Left rotate, amount never zero here
   function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] n);
      logic [5:0] m;
      m = 6'd32 - {1'b0, n};
      return (x << n) | (x >> m);
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/md5_hash_engine_core.sv
// Channel   Direction  tdata                 tuser               tlast
// req_      in         [7:0] data_byte       [0] message_empty   is_last
// rsp_      out        [31:0] digest_word    [1:0] word_index    last_word
//
// A byte that neither fills a block nor ends the message is followed by a check
// step before the next byte is taken. A byte that fills a block adds one compression:
// 64 round steps of the single shared round unit plus load, add and dispatch steps.
// The last item adds padding, one compression and the four digest words (held while
// rsp_ stalls); a fill of 56 or more adds one more compression plus 16 block clearing
// steps. Reset is synchronous; the next message is taken while the last digest word
// still waits in the output register.
`default_nettype none

module md5_hash_engine_core
   import md5_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] message_empty
   input  wire logic        req_tlast,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] digest_word
   output logic [1:0]       rsp_tuser,   // [1:0] word_index
   output logic             rsp_tlast
);

   ctrl_type    ctrl;
   dp_stat_type stat;
   logic        item_acc;
   logic        slot_free;
   logic        emit_go;
   logic        emit_more;
   logic [31:0] digest_word;

   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic [1:0]  rsp_idx_ff;
   logic        rsp_last_ff;
   logic [1:0]  emit_idx_ff;

   assign req_tready = ctrl.ready;
   assign item_acc   = req_tvalid && ctrl.ready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign emit_go    = (ctrl.op == OP_EMIT) && slot_free;
   assign emit_more  = !(emit_go && (emit_idx_ff == 2'd3));

   md5_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .item_acc  (item_acc),
      .emit_more (emit_more),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   md5_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .item_acc      (item_acc),
      .data_byte     (req_tdata),
      .is_last       (req_tlast),
      .message_empty (req_tuser),
      .emit_idx      (emit_idx_ff),
      .digest_word   (digest_word),
      .stat          (stat)
   );

   // Output register, one digest word per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
         emit_idx_ff  <= 2'(emit_idx_ff + 2'd1);
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_data_ff <= digest_word;
         rsp_idx_ff  <= emit_idx_ff;
         rsp_last_ff <= (emit_idx_ff == 2'd3);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idx_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/md5_seq.sv
`default_nettype none

module md5_seq
   import md5_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_acc,
   input  wire logic        emit_more,
   input  wire dp_stat_type stat,
   output ctrl_type         ctrl
);

   // Jump condition codes
   localparam logic [3:0] C_NEVER      = 4'd0;
   localparam logic [3:0] C_ALWAYS     = 4'd1;
   localparam logic [3:0] C_NOT_ACC    = 4'd2;
   localparam logic [3:0] C_IDLE_NEXT  = 4'd3;
   localparam logic [3:0] C_NOT_FULL   = 4'd4;
   localparam logic [3:0] C_ROUND_MORE = 4'd5;
   localparam logic [3:0] C_CTX_FINAL  = 4'd6;
   localparam logic [3:0] C_CTX_PADA   = 4'd7;
   localparam logic [3:0] C_NOT_LAST   = 4'd8;
   localparam logic [3:0] C_PAD_MORE   = 4'd9;
   localparam logic [3:0] C_NOT_WIDE   = 4'd10;
   localparam logic [3:0] C_ZERO_MORE  = 4'd11;
   localparam logic [3:0] C_EMIT_MORE  = 4'd12;

   // Program addresses that are jump targets
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOAD   = 4'd3;
   localparam logic [3:0] S_ROUND  = 4'd4;
   localparam logic [3:0] S_PAD    = 4'd8;
   localparam logic [3:0] S_PADB   = 4'd9;
   localparam logic [3:0] S_ZERO   = 4'd12;
   localparam logic [3:0] S_LEN    = 4'd13;
   localparam logic [3:0] S_EMIT   = 4'd14;

   typedef struct packed {
      logic       ready;
      logic [3:0] op;
      logic [3:0] cond;
      logic [3:0] target;
   } uword_type;

   logic [3:0] upc_ff, upc_in;
   uword_type  uw;
   logic       take;

   // Control store
   always_comb begin
      case (upc_ff)
         4'd0:    uw = '{1'b1, OP_ABSORB,   C_NOT_ACC,    S_IDLE};
         4'd1:    uw = '{1'b0, OP_NOP,      C_IDLE_NEXT,  S_IDLE};
         4'd2:    uw = '{1'b0, OP_NOP,      C_NOT_FULL,   S_PAD};
         4'd3:    uw = '{1'b0, OP_LOAD,     C_NEVER,      S_IDLE};
         4'd4:    uw = '{1'b0, OP_ROUND,    C_ROUND_MORE, S_ROUND};
         4'd5:    uw = '{1'b0, OP_ADD,      C_CTX_FINAL,  S_EMIT};
         4'd6:    uw = '{1'b0, OP_NOP,      C_CTX_PADA,   S_ZERO};
         4'd7:    uw = '{1'b0, OP_NOP,      C_NOT_LAST,   S_IDLE};
         4'd8:    uw = '{1'b0, OP_PADINIT,  C_NEVER,      S_IDLE};
         4'd9:    uw = '{1'b0, OP_PADBYTE,  C_PAD_MORE,   S_PADB};
         4'd10:   uw = '{1'b0, OP_CTX_PADA, C_NOT_WIDE,   S_LEN};
         4'd11:   uw = '{1'b0, OP_NOP,      C_ALWAYS,     S_LOAD};
         4'd12:   uw = '{1'b0, OP_ZERO,     C_ZERO_MORE,  S_ZERO};
         4'd13:   uw = '{1'b0, OP_LEN,      C_ALWAYS,     S_LOAD};
         4'd14:   uw = '{1'b0, OP_EMIT,     C_EMIT_MORE,  S_EMIT};
         default: uw = '{1'b0, OP_CLEAR,    C_ALWAYS,     S_IDLE};
      endcase
   end

   // Condition select
   always_comb begin
      case (uw.cond)
         C_NEVER:      take = 1'b0;
         C_ALWAYS:     take = 1'b1;
         C_NOT_ACC:    take = !item_acc;
         C_IDLE_NEXT:  take = stat.idle_next;
         C_NOT_FULL:   take = stat.not_full;
         C_ROUND_MORE: take = stat.round_more;
         C_CTX_FINAL:  take = stat.ctx_final;
         C_CTX_PADA:   take = stat.ctx_pada;
         C_NOT_LAST:   take = stat.not_last;
         C_PAD_MORE:   take = stat.pad_more;
         C_NOT_WIDE:   take = stat.not_wide;
         C_ZERO_MORE:  take = stat.zero_more;
         C_EMIT_MORE:  take = emit_more;
         default:      take = 1'b0;
      endcase
   end

   assign upc_in     = take ? uw.target : 4'(upc_ff + 4'd1);
   assign ctrl.ready = uw.ready;
   assign ctrl.op    = uw.op;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/md5_dp.sv
`default_nettype none

module md5_dp
   import md5_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctrl_type    ctrl,
   input  wire logic        item_acc,
   input  wire logic [7:0]  data_byte,
   input  wire logic        is_last,
   input  wire logic        message_empty,
   input  wire logic [1:0]  emit_idx,
   output logic [31:0]      digest_word,
   output dp_stat_type      stat
);

   // What the current compression returns to
   localparam logic [1:0] CTX_DATA  = 2'd0;
   localparam logic [1:0] CTX_PADA  = 2'd1;
   localparam logic [1:0] CTX_FINAL = 2'd2;

   logic [31:0] chain_ff [4];
   logic [31:0] work_ff  [4];
   logic [31:0] words_ff [16];
   logic [31:0] pre_ff;
   logic [63:0] len_ff;
   logic [5:0]  pos_ff;
   logic [5:0]  step_ff;
   logic [1:0]  ctx_ff;
   logic        full_ff;
   logic        last_ff;
   logic        wide_ff;
   logic        first_ff;

   logic        wr_en;
   logic [7:0]  wr_byte;
   logic [5:0]  pre_step;
   logic [31:0] fn;
   logic [31:0] sum;
   logic [31:0] new_b;

   // Byte lane write source
   always_comb begin
      wr_en   = 1'b0;
      wr_byte = data_byte;
      if (ctrl.op == OP_ABSORB) begin
         wr_en = item_acc && !message_empty;
      end else if (ctrl.op == OP_PADBYTE) begin
         wr_en   = 1'b1;
         wr_byte = first_ff ? PAD_BYTE : 8'h00;
      end
   end

   // Round function
   always_comb begin
      case (step_ff[5:4])
         2'd0:    fn = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         2'd1:    fn = (work_ff[3] & work_ff[1]) | (~work_ff[3] & work_ff[2]);
         2'd2:    fn = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         default: fn = work_ff[2] ^ (work_ff[1] | ~work_ff[3]);
      endcase
      sum   = fn + work_ff[0] + pre_ff;
      new_b = work_ff[1] + md5_rotl(sum, md5_rot(step_ff));
   end

   // Next step's constant plus message word, registered during the preceding step
   assign pre_step = (ctrl.op == OP_LOAD) ? 6'd0 : 6'(step_ff + 6'd1);

   // Message block and working registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (pos_ff[1:0])
            2'd0:    words_ff[pos_ff[5:2]] <= {24'h0, wr_byte};
            2'd1:    words_ff[pos_ff[5:2]][15:8]  <= wr_byte;
            2'd2:    words_ff[pos_ff[5:2]][23:16] <= wr_byte;
            default: words_ff[pos_ff[5:2]][31:24] <= wr_byte;
         endcase
      end
      if (ctrl.op == OP_ZERO) begin
         words_ff[step_ff[3:0]] <= 32'h0;
      end
      if (ctrl.op == OP_LEN) begin
         words_ff[14] <= len_ff[31:0];
         words_ff[15] <= len_ff[63:32];
      end
      if (ctrl.op == OP_LOAD || ctrl.op == OP_ROUND) begin
         pre_ff <= md5_k(pre_step) + words_ff[md5_gidx(pre_step)];
      end
      if (ctrl.op == OP_LOAD) begin
         work_ff <= chain_ff;
      end else if (ctrl.op == OP_ROUND) begin
         work_ff[0] <= work_ff[3];
         work_ff[1] <= new_b;
         work_ff[2] <= work_ff[1];
         work_ff[3] <= work_ff[2];
      end
   end

   // Chain, counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '{IV_A, IV_B, IV_C, IV_D};
         len_ff   <= '0;
         pos_ff   <= '0;
         step_ff  <= '0;
         ctx_ff   <= CTX_DATA;
         full_ff  <= 1'b0;
         last_ff  <= 1'b0;
         wide_ff  <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         case (ctrl.op)
            OP_ABSORB: begin
               if (item_acc) begin
                  last_ff <= is_last;
                  full_ff <= !message_empty && (pos_ff == 6'd63);
                  if (!message_empty) begin
                     pos_ff <= 6'(pos_ff + 6'd1);
                     len_ff <= 64'(len_ff + 64'd8);
                  end
               end
            end
            OP_LOAD:  step_ff <= '0;
            OP_ROUND: step_ff <= 6'(step_ff + 6'd1);
            OP_ADD: begin
               chain_ff[0] <= chain_ff[0] + work_ff[0];
               chain_ff[1] <= chain_ff[1] + work_ff[1];
               chain_ff[2] <= chain_ff[2] + work_ff[2];
               chain_ff[3] <= chain_ff[3] + work_ff[3];
            end
            OP_PADINIT: begin
               wide_ff  <= (pos_ff[5:3] == 3'b111);
               first_ff <= 1'b1;
            end
            OP_PADBYTE: begin
               first_ff <= 1'b0;
               pos_ff   <= 6'(pos_ff + 6'd1);
            end
            OP_CTX_PADA: ctx_ff  <= CTX_PADA;
            OP_ZERO:     step_ff <= 6'(step_ff + 6'd1);
            OP_LEN:      ctx_ff  <= CTX_FINAL;
            OP_CLEAR: begin
               chain_ff <= '{IV_A, IV_B, IV_C, IV_D};
               len_ff   <= '0;
               pos_ff   <= '0;
               step_ff  <= '0;
               ctx_ff   <= CTX_DATA;
               full_ff  <= 1'b0;
               last_ff  <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign digest_word = chain_ff[emit_idx];

   // Status for the sequencer
   assign stat.idle_next  = !full_ff && !last_ff;
   assign stat.not_full   = !full_ff;
   assign stat.round_more = (step_ff != 6'd63);
   assign stat.ctx_final  = (ctx_ff == CTX_FINAL);
   assign stat.ctx_pada   = (ctx_ff == CTX_PADA);
   assign stat.not_last   = !last_ff;
   assign stat.pad_more   = (pos_ff != 6'd63);
   assign stat.not_wide   = !wide_ff;
   assign stat.zero_more  = (step_ff[3:0] != 4'd15);

endmodule

`default_nettype wire
